[design/spwb_pkg.sv]
// shared types and constants for the splat weight brush pipeline
// no dependencies
package spwb_pkg;

    localparam int MAP_SIZE_DEF = 1024;
    localparam int SQRT_STEPS   = 19;
    localparam int FDIV_STEPS   = 16;
    localparam int RDIV_STEPS   = 8;
    localparam int LANES        = 3;

    localparam logic [16:0] FULL_F  = 17'h10000;
    localparam logic [7:0]  W_MAX   = 8'd255;
    localparam logic [8:0]  HARD_H  = 9'd256;

    typedef enum logic [2:0] {
        CFG_CENTER_X   = 3'd0,
        CFG_CENTER_Z   = 3'd1,
        CFG_RADIUS     = 3'd2,
        CFG_HARDNESS   = 3'd3,
        CFG_STRENGTH   = 3'd4,
        CFG_LAYER      = 3'd5
    } cfg_idx_t;

    // per-pixel sideband that rides along every stage
    typedef struct packed {
        logic            pass;
        logic [1:0]      sel;
        logic [3:0][7:0] w;
    } side_t;

endpackage

[design/spwb_sqrt.sv]
// pipelined integer square root of d2 * 65536, one result bit per stage
// depends on spwb_pkg
module spwb_sqrt
    import spwb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        vld_in,
    input  side_t       sd_in,
    input  logic [20:0] d2_in,
    output logic        vld_out,
    output side_t       sd_out,
    output logic [18:0] d_out
);

    logic        vld_s [0:SQRT_STEPS];
    side_t       sd_s  [0:SQRT_STEPS];
    logic [37:0] v_s   [0:SQRT_STEPS];
    logic [37:0] r_s   [0:SQRT_STEPS];

    assign vld_s[0] = vld_in;
    assign sd_s[0]  = sd_in;
    assign v_s[0]   = {1'b0, d2_in, 16'b0};
    assign r_s[0]   = '0;

    for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_stage
        localparam logic [37:0] BIT = 38'(1) << (36 - 2 * i);
        logic [37:0] t;
        logic [37:0] v_next;
        logic [37:0] r_next;

        always_comb
        begin
            t = r_s[i] + BIT;
            if (v_s[i] >= t)
            begin
                v_next = v_s[i] - t;
                r_next = (r_s[i] >> 1) + BIT;
            end
            else
            begin
                v_next = v_s[i];
                r_next = r_s[i] >> 1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_s[i+1] <= 1'b0;
            else
                vld_s[i+1] <= vld_s[i];
        end

        always_ff @(posedge clk)
        begin
            sd_s[i+1] <= sd_s[i];
            v_s[i+1]  <= v_next;
            r_s[i+1]  <= r_next;
        end
    end

    assign vld_out = vld_s[SQRT_STEPS];
    assign sd_out  = sd_s[SQRT_STEPS];
    assign d_out   = r_s[SQRT_STEPS][18:0];

endmodule

[design/spwb_fdiv.sv]
// pipelined restoring divider for the falloff factor, num * 2^24 / den, clamped
// depends on spwb_pkg
module spwb_fdiv
    import spwb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        vld_in,
    input  side_t       sd_in,
    input  logic [15:0] num_in,
    input  logic [23:0] den_in,
    input  logic        zero_in,
    input  logic        hard_in,
    output logic        vld_out,
    output side_t       sd_out,
    output logic [16:0] f_out
);

    logic        vld_s  [0:FDIV_STEPS];
    side_t       sd_s   [0:FDIV_STEPS];
    logic [23:0] r_s    [0:FDIV_STEPS];
    logic [23:0] den_s  [0:FDIV_STEPS];
    logic [15:0] q_s    [0:FDIV_STEPS];
    logic        zero_s [0:FDIV_STEPS];
    logic        full_s [0:FDIV_STEPS];

    assign vld_s[0]  = vld_in;
    assign sd_s[0]   = sd_in;
    assign r_s[0]    = {num_in, 8'b0};
    assign den_s[0]  = den_in;
    assign q_s[0]    = '0;
    assign zero_s[0] = zero_in;
    // quotient of 2^16 or more saturates to full
    assign full_s[0] = hard_in || ({num_in, 8'b0} >= den_in);

    for (genvar i = 0; i < FDIV_STEPS; i++) begin : g_stage
        logic [24:0] t;
        logic        ge;

        always_comb
        begin
            t  = {r_s[i], 1'b0};
            ge = (t >= {1'b0, den_s[i]});
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_s[i+1] <= 1'b0;
            else
                vld_s[i+1] <= vld_s[i];
        end

        always_ff @(posedge clk)
        begin
            sd_s[i+1]   <= sd_s[i];
            r_s[i+1]    <= ge ? 24'(t - {1'b0, den_s[i]}) : t[23:0];
            den_s[i+1]  <= den_s[i];
            q_s[i+1]    <= {q_s[i][14:0], ge};
            zero_s[i+1] <= zero_s[i];
            full_s[i+1] <= full_s[i];
        end
    end

    assign vld_out = vld_s[FDIV_STEPS];
    assign sd_out  = sd_s[FDIV_STEPS];
    assign f_out   = zero_s[FDIV_STEPS] ? 17'd0 :
                     full_s[FDIV_STEPS] ? FULL_F : {1'b0, q_s[FDIV_STEPS]};

endmodule

[design/spwb_rdiv.sv]
// three-lane pipelined divider that shares the remainder, o * rem / sum
// depends on spwb_pkg
module spwb_rdiv
    import spwb_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  vld_in,
    input  side_t                 sd_in,
    input  logic [7:0]            rem_in,
    input  logic [9:0]            sum_in,
    input  logic [LANES-1:0][7:0] oth_in,
    output logic                  vld_out,
    output side_t                 sd_out,
    output logic [LANES-1:0][7:0] q_out
);

    logic                  vld_s [0:RDIV_STEPS];
    side_t                 sd_s  [0:RDIV_STEPS];
    logic [9:0]            sum_s [0:RDIV_STEPS];
    logic [LANES-1:0][9:0] r_s   [0:RDIV_STEPS];
    logic [LANES-1:0][7:0] lo_s  [0:RDIV_STEPS];
    logic [LANES-1:0][7:0] q_s   [0:RDIV_STEPS];
    logic [LANES-1:0][15:0] prod;

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
            prod[l] = 16'(oth_in[l]) * 16'(rem_in);
    end

    // product stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_s[0] <= 1'b0;
        else
            vld_s[0] <= vld_in;
    end

    always_ff @(posedge clk)
    begin
        sd_s[0]  <= sd_in;
        sum_s[0] <= sum_in;
        for (int l = 0; l < LANES; l++)
        begin
            r_s[0][l]  <= {2'b0, prod[l][15:8]};
            lo_s[0][l] <= prod[l][7:0];
            q_s[0][l]  <= '0;
        end
    end

    for (genvar i = 0; i < RDIV_STEPS; i++) begin : g_stage
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_s[i+1] <= 1'b0;
            else
                vld_s[i+1] <= vld_s[i];
        end

        always_ff @(posedge clk)
        begin
            sd_s[i+1]  <= sd_s[i];
            sum_s[i+1] <= sum_s[i];
        end

        for (genvar l = 0; l < LANES; l++) begin : g_lane
            logic [10:0] t;
            logic        ge;

            always_comb
            begin
                t  = {r_s[i][l], lo_s[i][l][7]};
                ge = (t >= {1'b0, sum_s[i]});
            end

            always_ff @(posedge clk)
            begin
                r_s[i+1][l]  <= ge ? 10'(t - {1'b0, sum_s[i]}) : t[9:0];
                lo_s[i+1][l] <= {lo_s[i][l][6:0], 1'b0};
                q_s[i+1][l]  <= {q_s[i][l][6:0], ge};
            end
        end
    end

    assign vld_out = vld_s[RDIV_STEPS];
    assign sd_out  = sd_s[RDIV_STEPS];

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
            q_out[l] = (sum_s[RDIV_STEPS] == 10'd0) ? 8'd0 : q_s[RDIV_STEPS][l];
    end

endmodule

[design/splat_weight_brush_pixel.sv]
// top level of the splat weight brush: config registers, distance, blend and output stages
// depends on spwb_pkg, spwb_sqrt, spwb_fdiv, spwb_rdiv

// One pixel enters per clock and its new weights come out of the output
// register, one result per pixel, in order, on a single-cycle done strobe.
// busy stays low: the pipeline never stalls and the result side has no
// backpressure. It is built from the 19-stage square root, the 16-stage
// falloff divider, the 9-stage weight share divider and eight datapath stages.
// Register writes are always ready and take effect at once; change them only
// while no pixel is in flight.
module splat_weight_brush_pixel
    import spwb_pkg::*;
#(
    parameter int MAP_SIZE = MAP_SIZE_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [9:0]  pix_x,
    input  logic [9:0]  pix_z,
    input  logic [7:0]  in_w0,
    input  logic [7:0]  in_w1,
    input  logic [7:0]  in_w2,
    input  logic [7:0]  in_w3,
    output logic        done,
    output logic [7:0]  out_w0,
    output logic [7:0]  out_w1,
    output logic [7:0]  out_w2,
    output logic [7:0]  out_w3,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    logic [9:0]  center_x_reg;
    logic [9:0]  center_z_reg;
    logic [15:0] radius_reg;
    logic [8:0]  hardness_reg;
    logic [15:0] strength_reg;
    logic [2:0]  layer_reg;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg <= 10'd0;
            center_z_reg <= 10'd0;
            radius_reg   <= 16'd1280;
            hardness_reg <= 9'd0;
            strength_reg <= 16'd256;
            layer_reg    <= 3'd1;
        end
        else if (cfg_valid)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_CENTER_X: center_x_reg <= cfg_data[9:0];
                CFG_CENTER_Z: center_z_reg <= cfg_data[9:0];
                CFG_RADIUS:   radius_reg   <= cfg_data;
                CFG_HARDNESS: hardness_reg <= cfg_data[8:0];
                CFG_STRENGTH: strength_reg <= cfg_data;
                CFG_LAYER:    layer_reg    <= cfg_data[2:0];
                default: ;
            endcase
        end
    end

    // ---------------- stage 0: capture
    logic        v0_reg, v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;
    logic        sq_vld, fd_vld;
    logic [9:0]  px0_reg, pz0_reg;
    side_t       sd0_reg, sd1_reg, sd2_reg, sd3_reg, sd4_reg, sd5_reg, sd6_reg;
    side_t       sd0_next;

    always_comb
    begin
        sd0_next.pass = (layer_reg < 3'd1) || (layer_reg > 3'd4) ||
                        (32'(pix_x) >= MAP_SIZE) || (32'(pix_z) >= MAP_SIZE);
        sd0_next.sel  = 2'(layer_reg - 3'd1);
        sd0_next.w    = {in_w3, in_w2, in_w1, in_w0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else
        begin
            v0_reg <= start && !busy;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            v3_reg <= sq_vld;
            v4_reg <= fd_vld;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
        end
    end

    // ---------------- stages 1, 2: distance squared
    logic [9:0]  dx1_reg, dz1_reg;
    logic [20:0] d2_reg;

    always_ff @(posedge clk)
    begin
        px0_reg <= pix_x;
        pz0_reg <= pix_z;
        sd0_reg <= sd0_next;
        dx1_reg <= (px0_reg >= center_x_reg) ? px0_reg - center_x_reg
                                             : center_x_reg - px0_reg;
        dz1_reg <= (pz0_reg >= center_z_reg) ? pz0_reg - center_z_reg
                                             : center_z_reg - pz0_reg;
        sd1_reg <= sd0_reg;
        d2_reg  <= 21'(20'(dx1_reg) * 20'(dx1_reg)) + 21'(20'(dz1_reg) * 20'(dz1_reg));
        sd2_reg <= sd1_reg;
    end

    side_t       sq_sd;
    logic [18:0] sq_d;

    spwb_sqrt u_sqrt (
        .clk     (clk),
        .rst_n   (rst_n),
        .vld_in  (v2_reg),
        .sd_in   (sd2_reg),
        .d2_in   (d2_reg),
        .vld_out (sq_vld),
        .sd_out  (sq_sd),
        .d_out   (sq_d)
    );

    // ---------------- stage 3: falloff numerator and denominator
    logic [15:0] num3_reg;
    logic [23:0] den3_reg;
    logic        zero3_reg, hard3_reg;
    logic [24:0] den_full;

    assign den_full = 25'(radius_reg) * 25'(HARD_H - hardness_reg);

    always_ff @(posedge clk)
    begin
        num3_reg  <= ({3'b0, radius_reg} > sq_d) ? 16'({3'b0, radius_reg} - sq_d) : 16'd0;
        zero3_reg <= !({3'b0, radius_reg} > sq_d);
        hard3_reg <= (hardness_reg >= HARD_H);
        den3_reg  <= den_full[23:0];
        sd3_reg   <= sq_sd;
    end

    side_t       fd_sd;
    logic [16:0] fd_f;

    spwb_fdiv u_fdiv (
        .clk     (clk),
        .rst_n   (rst_n),
        .vld_in  (v3_reg),
        .sd_in   (sd3_reg),
        .num_in  (num3_reg),
        .den_in  (den3_reg),
        .zero_in (zero3_reg),
        .hard_in (hard3_reg),
        .vld_out (fd_vld),
        .sd_out  (fd_sd),
        .f_out   (fd_f)
    );

    // ---------------- stages 4, 5: intensity and raise amount
    logic [32:0] amt4_reg;
    logic [7:0]  inv4_reg;
    logic [40:0] prod5_reg;

    always_ff @(posedge clk)
    begin
        amt4_reg  <= 33'(fd_f) * 33'(strength_reg);
        inv4_reg  <= W_MAX - fd_sd.w[fd_sd.sel];
        sd4_reg   <= fd_sd;
        prod5_reg <= 41'(amt4_reg) * 41'(inv4_reg);
        sd5_reg   <= sd4_reg;
    end

    // ---------------- stage 6: new selected weight, remainder, others
    logic [7:0]            rem6_reg;
    logic [9:0]            sum6_reg;
    logic [LANES-1:0][7:0] oth6_reg;
    logic [7:0]            wsel5;
    logic [17:0]           raised;
    logic [7:0]            nsel;
    logic [LANES-1:0][7:0] oth_next;
    logic [9:0]            sum_next;
    side_t                 sd6_next;

    always_comb
    begin
        wsel5  = sd5_reg.w[sd5_reg.sel];
        raised = 18'(wsel5) + 18'(prod5_reg[40:24]);
        nsel   = (raised > 18'(W_MAX)) ? W_MAX : raised[7:0];
        sum_next = '0;
        for (int j = 0; j < LANES; j++)
        begin
            oth_next[j] = (2'(j) < sd5_reg.sel) ? sd5_reg.w[j] : sd5_reg.w[j + 1];
            sum_next    = sum_next + 10'(oth_next[j]);
        end
        sd6_next = sd5_reg;
        if (!sd5_reg.pass)
            sd6_next.w[sd5_reg.sel] = nsel;
    end

    always_ff @(posedge clk)
    begin
        rem6_reg <= W_MAX - nsel;
        sum6_reg <= sum_next;
        oth6_reg <= oth_next;
        sd6_reg  <= sd6_next;
    end

    logic                  rd_vld;
    side_t                 rd_sd;
    logic [LANES-1:0][7:0] rd_q;

    spwb_rdiv u_rdiv (
        .clk     (clk),
        .rst_n   (rst_n),
        .vld_in  (v6_reg),
        .sd_in   (sd6_reg),
        .rem_in  (rem6_reg),
        .sum_in  (sum6_reg),
        .oth_in  (oth6_reg),
        .vld_out (rd_vld),
        .sd_out  (rd_sd),
        .q_out   (rd_q)
    );

    // ---------------- output register
    logic            done_reg;
    logic            pass_out_reg;
    logic [3:0][7:0] w_out_reg;
    logic [3:0][7:0] w_out_next;

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            if (rd_sd.pass || 2'(k) == rd_sd.sel)
                w_out_next[k] = rd_sd.w[k];
            else if (2'(k) < rd_sd.sel)
                w_out_next[k] = rd_q[k];
            else
                w_out_next[k] = rd_q[(k == 0) ? 0 : k - 1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= rd_vld;
    end

    always_ff @(posedge clk)
    begin
        w_out_reg    <= w_out_next;
        pass_out_reg <= rd_sd.pass;
    end

    assign done   = done_reg;
    assign out_w0 = w_out_reg[0];
    assign out_w1 = w_out_reg[1];
    assign out_w2 = w_out_reg[2];
    assign out_w3 = w_out_reg[3];

    // a result leaves after its blend stage, through the weight share divider and the output register
    a_done_follows_blend: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(v6_reg, 10))
        else $error("result strobe without matching blend stage");

    // painted pixels never hold more than full weight in total
    a_weight_total: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !pass_out_reg) |->
            (10'(out_w0) + 10'(out_w1) + 10'(out_w2) + 10'(out_w3) <= 10'(W_MAX)))
        else $error("painted weights exceed full scale");

    // every started transaction enters the pipeline
    a_start_enters: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> v0_reg)
        else $error("accepted transaction lost at entry");

endmodule
